@@ src/lss_pkg.sv @@
package lss_pkg;

    localparam int CoordW = 32;
    localparam int LineW  = 16;
    localparam int DistW  = 50;
    localparam int FracW  = 16;
    localparam int CfgIdxW = 3;

    typedef enum logic [1:0] {
        SIDE_FRONT    = 2'd0,
        SIDE_BACK     = 2'd1,
        SIDE_COPLANAR = 2'd2
    } t_side;

    typedef enum logic [CfgIdxW-1:0] {
        REG_POINT_X   = 3'd0,
        REG_POINT_Y   = 3'd1,
        REG_NORMAL_X  = 3'd2,
        REG_NORMAL_Y  = 3'd3,
        REG_TOLERANCE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
        logic [LineW-1:0]         line;
        logic                     fin;
    } t_seg;

    typedef struct packed {
        t_seg  seg;
        logic  whole;
        t_side wside;
        t_side side0;
        t_side side1;
        logic  bzero;
    } t_tag;

endpackage

@@ src/lss_divider.sv @@
module lss_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [lss_pkg::DistW-1:0]   i_num,
    input  logic [lss_pkg::DistW-1:0]   i_den,
    input  lss_pkg::t_tag               i_tag,
    output logic                        o_valid,
    output logic [lss_pkg::FracW-1:0]   o_quot,
    output lss_pkg::t_tag               o_tag
);
    import lss_pkg::*;

    // Restoring division, one quotient bit per stage.
    logic             w_v   [0:FracW];
    logic [DistW-1:0] w_rem [0:FracW];
    logic [DistW-1:0] w_den [0:FracW];
    logic [FracW-1:0] w_q   [0:FracW];
    t_tag             w_tag [0:FracW];

    assign w_v[0]   = i_valid;
    assign w_rem[0] = i_num;
    assign w_den[0] = i_den;
    assign w_q[0]   = '0;
    assign w_tag[0] = i_tag;

    for (genvar k = 1; k <= FracW; k++) begin : g_stage
        logic [DistW:0]   n_r2;
        logic             n_ge;
        logic             r_v;
        logic [DistW-1:0] r_rem;
        logic [DistW-1:0] r_den;
        logic [FracW-1:0] r_q;
        t_tag             r_tag;

        assign n_r2 = {w_rem[k-1], 1'b0};
        assign n_ge = n_r2 >= {1'b0, w_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_ge ? DistW'(n_r2 - {1'b0, w_den[k-1]}) : DistW'(n_r2);
                r_den <= w_den[k-1];
                r_q   <= {w_q[k-1][FracW-2:0], n_ge};
                r_tag <= w_tag[k-1];
            end
        end

        assign w_v[k]   = r_v;
        assign w_rem[k] = r_rem;
        assign w_den[k] = r_den;
        assign w_q[k]   = r_q;
        assign w_tag[k] = r_tag;
    end

    assign o_valid = w_v[FracW];
    assign o_quot  = w_q[FracW];
    assign o_tag   = w_tag[FracW];

endmodule

@@ src/line_segment_splitter.sv @@
// Splits one 2D segment per word against a configured line and streams out one
// word per piece: one word for a segment on one side, on the line or cut near an
// endpoint, two words for a segment that is cut. The pipeline takes a new segment
// in every cycle unless the output is back-pressured or the second word of a cut
// segment is pending, as the single result port sends one word at a time. The
// 16-stage divider forms the cut fraction. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
module line_segment_splitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    // start_x, start_y, end_x, end_y, source_line
    input  logic [143:0]   i_s_axis_tdata,
    input  logic           i_s_axis_tlast,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    // piece_start_x, piece_start_y, piece_end_x, piece_end_y, piece_line
    output logic [143:0]   o_m_axis_tdata,
    // side, set_done
    output logic [2:0]     o_m_axis_tuser,
    output logic           o_m_axis_tlast
);
    import lss_pkg::*;

    typedef struct packed {
        t_tag                     tag;
        logic signed [CoordW-1:0] ix;
        logic signed [CoordW-1:0] iy;
    } t_em;

    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_nx, r_ny;
    logic [15:0]        r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_nx  <= '0;
            r_ny  <= 16'sd16384;
            r_tol <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POINT_X:   r_px  <= i_cfg_data;
                REG_POINT_Y:   r_py  <= i_cfg_data;
                REG_NORMAL_X:  r_nx  <= i_cfg_data[15:0];
                REG_NORMAL_Y:  r_ny  <= i_cfg_data[15:0];
                REG_TOLERANCE: r_tol <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_free;
    logic em_take;
    t_seg in_seg;

    assign in_seg.sx   = i_s_axis_tdata[31:0];
    assign in_seg.sy   = i_s_axis_tdata[63:32];
    assign in_seg.ex   = i_s_axis_tdata[95:64];
    assign in_seg.ey   = i_s_axis_tdata[127:96];
    assign in_seg.line = i_s_axis_tdata[143:128];
    assign in_seg.fin  = i_s_axis_tlast;

    // Stage 1: offsets from the line point.
    logic r_v1;
    t_seg r_seg1;
    logic signed [32:0] r_dx0, r_dy0, r_dx1, r_dy1;
    // Stage 2: products with the normal.
    logic r_v2;
    t_seg r_seg2;
    logic signed [48:0] r_m0x, r_m0y, r_m1x, r_m1y;
    // Stage 3: distances.
    logic r_v3;
    t_seg r_seg3;
    logic signed [DistW-1:0] r_d0, r_d1;
    // Stage 4: tolerance and classification.
    logic r_v4;
    t_tag r_tag4;
    logic signed [DistW-1:0] r_e0, r_e1;
    logic r_z0, r_z1;
    // Stage 5: magnitudes.
    logic r_v5;
    t_tag r_tag5;
    logic [DistW-1:0] r_a5, r_b5;
    // Stage 6: divider operands.
    logic r_v6;
    t_tag r_tag6;
    logic [DistW-1:0] r_a6, r_s6;

    logic signed [DistW-1:0] eps;
    logic pos0, neg0, pos1, neg1, z0, z1;
    t_tag n_tag4;

    assign eps = DistW'({r_tol, 14'b0});
    assign z0  = (r_d0 <= eps) && (r_d0 >= -eps);
    assign z1  = (r_d1 <= eps) && (r_d1 >= -eps);
    assign pos0 = !z0 && !r_d0[DistW-1];
    assign neg0 = !z0 && r_d0[DistW-1];
    assign pos1 = !z1 && !r_d1[DistW-1];
    assign neg1 = !z1 && r_d1[DistW-1];

    always_comb begin
        n_tag4.seg   = r_seg3;
        n_tag4.whole = (pos0 && pos1) || (neg0 && neg1) || (z0 && z1);
        n_tag4.wside = (z0 && z1) ? SIDE_COPLANAR : (pos0 ? SIDE_FRONT : SIDE_BACK);
        n_tag4.side0 = pos0 ? SIDE_FRONT : SIDE_BACK;
        n_tag4.side1 = pos1 ? SIDE_FRONT : SIDE_BACK;
        n_tag4.bzero = z1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_seg1 <= in_seg;
            r_dx0  <= 33'(in_seg.sx) - 33'(r_px);
            r_dy0  <= 33'(in_seg.sy) - 33'(r_py);
            r_dx1  <= 33'(in_seg.ex) - 33'(r_px);
            r_dy1  <= 33'(in_seg.ey) - 33'(r_py);

            r_seg2 <= r_seg1;
            r_m0x  <= 49'(r_dx0) * 49'(r_nx);
            r_m0y  <= 49'(r_dy0) * 49'(r_ny);
            r_m1x  <= 49'(r_dx1) * 49'(r_nx);
            r_m1y  <= 49'(r_dy1) * 49'(r_ny);

            r_seg3 <= r_seg2;
            r_d0   <= DistW'(r_m0x) + DistW'(r_m0y);
            r_d1   <= DistW'(r_m1x) + DistW'(r_m1y);

            r_tag4 <= n_tag4;
            r_e0   <= r_d0;
            r_e1   <= r_d1;
            r_z0   <= z0;
            r_z1   <= z1;

            r_tag5 <= r_tag4;
            r_a5   <= r_z0 ? '0 : (r_e0[DistW-1] ? DistW'(-r_e0) : DistW'(r_e0));
            r_b5   <= r_z1 ? '0 : (r_e1[DistW-1] ? DistW'(-r_e1) : DistW'(r_e1));

            r_tag6 <= r_tag5;
            r_a6   <= r_a5;
            r_s6   <= r_a5 + r_b5;
        end
    end

    logic             dv_v;
    logic [FracW-1:0] dv_q;
    t_tag             dv_tag;

    lss_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v6),
        .i_num   (r_a6),
        .i_den   (r_s6),
        .i_tag   (r_tag6),
        .o_valid (dv_v),
        .o_quot  (dv_q),
        .o_tag   (dv_tag)
    );

    // Stage 7: endpoint tests on the fraction, spans of the segment.
    logic [16:0] t_full;
    logic        near_start, near_end;
    t_tag        n_tag7;

    assign t_full     = dv_tag.bzero ? 17'h10000 : {1'b0, dv_q};
    assign near_start = t_full <= {1'b0, r_tol};
    assign near_end   = (18'(t_full) + 18'(r_tol)) >= 18'h10000;

    always_comb begin
        n_tag7 = dv_tag;
        if (!dv_tag.whole) begin
            priority if (near_start) begin
                n_tag7.whole = 1'b1;
                n_tag7.wside = dv_tag.side1;
            end else if (near_end) begin
                n_tag7.whole = 1'b1;
                n_tag7.wside = dv_tag.side0;
            end else begin
                n_tag7.whole = 1'b0;
            end
        end
    end

    logic signed [32:0] span_x, span_y;
    assign span_x = 33'(dv_tag.seg.ex) - 33'(dv_tag.seg.sx);
    assign span_y = 33'(dv_tag.seg.ey) - 33'(dv_tag.seg.sy);

    logic r_v7, r_v8, r_v9, r_v10;
    t_tag r_tag7, r_tag8, r_tag9, r_tag10;
    logic [FracW-1:0] r_t7;
    logic [32:0] r_mx7, r_my7;
    logic r_nx7, r_ny7, r_nx8, r_ny8, r_nx9, r_ny9;
    logic [48:0] r_px8, r_py8;
    logic [31:0] r_rx9, r_ry9;
    logic signed [CoordW-1:0] r_ix10, r_iy10;
    logic [49:0] rnd_x, rnd_y;

    assign rnd_x = 50'(r_px8) + 50'd32768;
    assign rnd_y = 50'(r_py8) + 50'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v7  <= dv_v;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag7 <= n_tag7;
            r_t7   <= dv_q;
            r_nx7  <= span_x[32];
            r_ny7  <= span_y[32];
            r_mx7  <= span_x[32] ? 33'(-span_x) : 33'(span_x);
            r_my7  <= span_y[32] ? 33'(-span_y) : 33'(span_y);

            r_tag8 <= r_tag7;
            r_nx8  <= r_nx7;
            r_ny8  <= r_ny7;
            r_px8  <= 49'(r_mx7) * 49'(r_t7);
            r_py8  <= 49'(r_my7) * 49'(r_t7);

            r_tag9 <= r_tag8;
            r_nx9  <= r_nx8;
            r_ny9  <= r_ny8;
            r_rx9  <= rnd_x[47:16];
            r_ry9  <= rnd_y[47:16];

            r_tag10 <= r_tag9;
            r_ix10  <= r_nx9 ? r_tag9.seg.sx - r_rx9 : r_tag9.seg.sx + r_rx9;
            r_iy10  <= r_ny9 ? r_tag9.seg.sy - r_ry9 : r_tag9.seg.sy + r_ry9;
        end
    end

    // Piece sequencer and output register.
    logic r_em_v;
    logic r_em_phase;
    t_em  r_em;
    logic r_out_v;
    logic [143:0] r_out_data;
    logic [2:0]   r_out_user;
    logic         r_out_last;

    assign out_free = !r_out_v || i_m_axis_tready;
    assign em_take  = !r_em_v || (out_free && (r_em.tag.whole || r_em_phase));
    assign en       = em_take;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_v     <= 1'b0;
            r_em_phase <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (em_take) begin
                r_em_v     <= r_v10;
                r_em_phase <= 1'b0;
            end else if (out_free) begin
                r_em_phase <= 1'b1;
            end
            if (out_free) begin
                r_out_v <= r_em_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_take) begin
            r_em.tag <= r_tag10;
            r_em.ix  <= r_ix10;
            r_em.iy  <= r_iy10;
        end
        if (out_free) begin
            priority if (r_em.tag.whole) begin
                r_out_data <= {r_em.tag.seg.line, r_em.tag.seg.ey, r_em.tag.seg.ex,
                               r_em.tag.seg.sy, r_em.tag.seg.sx};
                r_out_user <= {r_em.tag.seg.fin, r_em.tag.wside};
                r_out_last <= 1'b1;
            end else if (!r_em_phase) begin
                r_out_data <= {r_em.tag.seg.line, r_em.iy, r_em.ix,
                               r_em.tag.seg.sy, r_em.tag.seg.sx};
                r_out_user <= {1'b0, r_em.tag.side0};
                r_out_last <= 1'b0;
            end else begin
                r_out_data <= {r_em.tag.seg.line, r_em.tag.seg.ey, r_em.tag.seg.ex,
                               r_em.iy, r_em.ix};
                r_out_user <= {r_em.tag.seg.fin, r_em.tag.side1};
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_em_v |-> o_s_axis_tready)
        else $error("input stalled with an empty piece sequencer");

    a_phase_only_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_em_v && r_em_phase) |-> !r_em.tag.whole)
        else $error("second piece pending for an uncut segment");

    a_first_piece_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |->
        (!o_m_axis_tuser[2] && o_m_axis_tuser[1:0] != SIDE_COPLANAR))
        else $error("first piece of a cut segment carries bad flags");

    a_second_piece_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> o_m_axis_tvalid)
        else $error("second piece of a cut segment did not follow");

endmodule
